>>> design/assert_macros.svh
// assertion macros shared by the box dedup table rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under async active-low reset
`define BDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under async active-low reset
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bdt_pkg.sv
// types, constants and compare helpers of the box dedup table
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package bdt_pkg;

    localparam int COORD_W     = 10;
    localparam int CORNER_W    = COORD_W + 1;
    localparam int COUNT_OUT_W = 7;
    localparam logic [COORD_W-1:0] TOL_RESET = 10'd30;

    // result codes
    typedef enum logic [1:0] {
        STATUS_NEW   = 2'd0,
        STATUS_MATCH = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // box held as its two corners, exact (no wrap)
    typedef struct packed {
        logic [CORNER_W-1:0] x1;
        logic [CORNER_W-1:0] y1;
        logic [CORNER_W-1:0] x2;
        logic [CORNER_W-1:0] y2;
    } corner_box_t;

    function automatic logic [CORNER_W-1:0] corner_dist(
        input logic [CORNER_W-1:0] a,
        input logic [CORNER_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // both corners closer than the tolerance on both axes
    function automatic logic box_near(
        input corner_box_t a,
        input corner_box_t b,
        input logic [COORD_W-1:0] tol
    );
        logic [CORNER_W-1:0] t;
        t = {1'b0, tol};
        return (corner_dist(a.x1, b.x1) < t) && (corner_dist(a.y1, b.y1) < t) &&
               (corner_dist(a.x2, b.x2) < t) && (corner_dist(a.y2, b.y2) < t);
    endfunction

endpackage

`default_nettype wire

>>> design/bdt_box_if.sv
// input channel carrying one detected box per beat
// depends on bdt_pkg for field widths
`default_nettype none

interface bdt_box_if;
    logic                        valid;
    logic                        ready;
    logic [bdt_pkg::COORD_W-1:0] box_x;
    logic [bdt_pkg::COORD_W-1:0] box_y;
    logic [bdt_pkg::COORD_W-1:0] box_width;
    logic [bdt_pkg::COORD_W-1:0] box_height;

    modport source (output valid, box_x, box_y, box_width, box_height, input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface

`default_nettype wire

>>> design/bdt_res_if.sv
// result channel carrying status and distinct count per beat
// depends on bdt_pkg for field widths
`default_nettype none

interface bdt_res_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      match_status;
    logic [bdt_pkg::COUNT_OUT_W-1:0] distinct_count;

    modport source (output valid, match_status, distinct_count, input ready);
    modport sink   (input valid, match_status, distinct_count, output ready);
endinterface

`default_nettype wire

>>> design/bdt_cfg_if.sv
// configuration write channel for the corner tolerance register
// depends on bdt_pkg for the register width
`default_nettype none

interface bdt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bdt_pkg::COORD_W-1:0] corner_tolerance;

    modport source (output valid, corner_tolerance, input ready);
    modport sink   (input valid, corner_tolerance, output ready);
endinterface

`default_nettype wire

>>> design/box_dedup_table_unit.sv
// top level of the box dedup table: sequencer, fill count and the row of cells
// depends on bdt_pkg, bdt_box_if, bdt_res_if, bdt_cfg_if, bdt_cell, assert_macros.svh
//
// usage
//   box: one detected box per beat (x, y, width, height), accepted on valid && ready.
//   result: one beat per box, match_status (0 stored, 1 matched, 2 table full,
//     dropped) and distinct_count, the number of stored boxes after that box.
//   cfg: writes corner_tolerance; always ready, write only while no box is in flight.
//   a box enters the row of TABLE_DEPTH cells and moves one cell per
//     cycle; the next box is taken only once the query has walked the
//     whole cell row and its result is committed; one box is in the row at a time.
//   the result sits in an output register, so the next box is taken while the
//     previous result still waits; if that result is still not taken when the
//     next scan ends, the sequencer holds until the receiver takes it.
//   reset: fill count zero, tolerance 30, no beat pending; stored entries are
//     not cleared, cells above the fill count are simply ignored.
`default_nettype none

`include "assert_macros.svh"

module box_dedup_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdt_box_if.sink    box,
    bdt_res_if.source  result,
    bdt_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    bdt_pkg::state_t              state_reg, state_next;
    logic [bdt_pkg::COORD_W-1:0]  tol_reg;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic                         inject_valid_reg;
    bdt_pkg::corner_box_t         inject_box_reg;

    logic                         fin_found_reg;
    bdt_pkg::corner_box_t         fin_box_reg;

    logic                         res_valid_reg;
    bdt_pkg::status_t             res_status_reg;
    logic [bdt_pkg::COUNT_OUT_W-1:0] res_count_reg;

    logic                         in_ready;
    logic                         fin_capture;
    logic                         commit;
    logic                         has_room;
    logic                         wr_en;
    bdt_pkg::status_t             status_next;

    logic                         chain_valid [TABLE_DEPTH];
    logic                         chain_found [TABLE_DEPTH];
    bdt_pkg::corner_box_t         chain_box   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       chain_valid_vec;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdt_pkg::ST_IDLE:
            begin
                if (box.valid)
                begin
                    state_next = bdt_pkg::ST_SCAN;
                end
            end
            bdt_pkg::ST_SCAN:
            begin
                if (chain_valid[TABLE_DEPTH-1])
                begin
                    state_next = bdt_pkg::ST_FINISH;
                end
            end
            bdt_pkg::ST_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next = bdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdt_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        fin_capture = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            bdt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bdt_pkg::ST_SCAN:
            begin
                fin_capture = chain_valid[TABLE_DEPTH-1];
            end
            bdt_pkg::ST_FINISH:
            begin
                commit = !res_valid_reg || result.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // tolerance register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= bdt_pkg::TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.corner_tolerance;
        end
    end

    // query injection into the first cell
    assign box.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inject_valid_reg <= 1'b0;
        end
        else
        begin
            inject_valid_reg <= in_ready && box.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && box.valid)
        begin
            inject_box_reg.x1 <= {1'b0, box.box_x};
            inject_box_reg.y1 <= {1'b0, box.box_y};
            inject_box_reg.x2 <= {1'b0, box.box_x} + {1'b0, box.box_width};
            inject_box_reg.y2 <= {1'b0, box.box_y} + {1'b0, box.box_height};
        end
    end

    // row of cells, the query steps one cell per cycle
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic                 c_in_valid;
            logic                 c_in_found;
            bdt_pkg::corner_box_t c_in_box;

            if (gi == 0)
            begin : g_head
                assign c_in_valid = inject_valid_reg;
                assign c_in_found = 1'b0;
                assign c_in_box   = inject_box_reg;
            end
            else
            begin : g_link
                assign c_in_valid = chain_valid[gi-1];
                assign c_in_found = chain_found[gi-1];
                assign c_in_box   = chain_box[gi-1];
            end

            bdt_cell #(
                .CELL_IDX (gi),
                .IDX_W    (IDX_W),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_in_valid),
                .in_found  (c_in_found),
                .in_box    (c_in_box),
                .out_valid (chain_valid[gi]),
                .out_found (chain_found[gi]),
                .out_box   (chain_box[gi]),
                .tol       (tol_reg),
                .count     (count_reg),
                .wr_en     (wr_en),
                .wr_idx    (count_reg[IDX_W-1:0]),
                .wr_box    (fin_box_reg)
            );

            assign chain_valid_vec[gi] = chain_valid[gi];
        end
    endgenerate

    // capture of the query leaving the last cell
    always_ff @(posedge clk)
    begin
        if (fin_capture)
        begin
            fin_found_reg <= chain_found[TABLE_DEPTH-1];
            fin_box_reg   <= chain_box[TABLE_DEPTH-1];
        end
    end

    // decision and table append
    assign has_room = count_reg < CNT_W'(TABLE_DEPTH);
    assign wr_en    = commit && !fin_found_reg && has_room;

    always_comb
    begin
        if (fin_found_reg)
        begin
            status_next = bdt_pkg::STATUS_MATCH;
        end
        else if (has_room)
        begin
            status_next = bdt_pkg::STATUS_NEW;
        end
        else
        begin
            status_next = bdt_pkg::STATUS_FULL;
        end
    end

    assign count_next = wr_en ? (count_reg + CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_status_reg <= status_next;
            res_count_reg  <= bdt_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.match_status   = res_status_reg;
    assign result.distinct_count = res_count_reg;

    // checks
    `BDT_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "fill count above table depth")
    `BDT_ASSERT_IMPLY(a_one_query, clk, rst_n, 1'b1, $countones({inject_valid_reg, chain_valid_vec}) <= 1, "more than one query in the cell row")
    `BDT_ASSERT_IMPLY(a_idle_row_empty, clk, rst_n, in_ready, !inject_valid_reg && (chain_valid_vec == '0), "box taken while a query is in the row")
    `BDT_ASSERT_NEXT(a_append_count, clk, rst_n, wr_en, count_reg == $past(count_reg) + CNT_W'(1), "append did not advance fill count")

endmodule

`default_nettype wire

>>> design/bdt_cell.sv
// one table cell: holds a stored box, compares the passing query and forwards it
// depends on bdt_pkg for the corner box type and compare function
`default_nettype none

module bdt_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_found,
    input  wire bdt_pkg::corner_box_t          in_box,
    output logic                               out_valid,
    output logic                               out_found,
    output bdt_pkg::corner_box_t               out_box,
    input  wire logic [bdt_pkg::COORD_W-1:0]   tol,
    input  wire logic [CNT_W-1:0]              count,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_idx,
    input  wire bdt_pkg::corner_box_t          wr_box
);

    bdt_pkg::corner_box_t entry_reg;
    logic                 valid_reg;
    logic                 found_reg;
    bdt_pkg::corner_box_t box_reg;
    logic                 occupied;
    logic                 hit;

    // entry counts only once the fill count has passed this cell
    assign occupied = CNT_W'(CELL_IDX) < count;
    assign hit      = occupied && bdt_pkg::box_near(in_box, entry_reg, tol);

    // stored entry, written once when the table grows into this cell
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IDX_W'(CELL_IDX)))
        begin
            entry_reg <= wr_box;
        end
    end

    // query stage handed to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= in_found | hit;
        box_reg   <= in_box;
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_box   = box_reg;

endmodule

`default_nettype wire

>>> tb/box_dedup_table_unit_tb.sv
// testbench of box_dedup_table_unit: directed and random boxes checked beat by beat
// against a dedup predictor; depends on bdt_pkg, bdt_box_if, bdt_res_if, bdt_cfg_if
// and the box_dedup_table_unit rtl

module box_dedup_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 64;
    localparam int CLK_PERIOD   = 8;
    localparam int MAX_GAP      = 10;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int RUN_LIMIT_NS = 6_000_000;
    localparam int COORD_MAX    = (1 << bdt_pkg::COORD_W) - 1;

    // one box as it travels on the input channel
    typedef struct packed {
        logic [bdt_pkg::COORD_W-1:0] x;
        logic [bdt_pkg::COORD_W-1:0] y;
        logic [bdt_pkg::COORD_W-1:0] w;
        logic [bdt_pkg::COORD_W-1:0] h;
    } box_beat_t;

    // stored box as its exact edges
    typedef struct packed {
        logic [bdt_pkg::CORNER_W-1:0] left;
        logic [bdt_pkg::CORNER_W-1:0] top;
        logic [bdt_pkg::CORNER_W-1:0] right;
        logic [bdt_pkg::CORNER_W-1:0] bottom;
    } box_edges_t;

    typedef struct packed {
        bdt_pkg::status_t                status;
        logic [bdt_pkg::COUNT_OUT_W-1:0] count;
    } dedup_result_t;

    // predictor of the table plus the queue of results still due
    class dedup_scoreboard;
        box_edges_t                  seen_boxes[$];
        dedup_result_t               due_results[$];
        logic [bdt_pkg::COORD_W-1:0] tolerance;
        int unsigned                 capacity;
        int unsigned                 mismatches;

        function new(int unsigned depth);
            capacity   = depth;
            tolerance  = bdt_pkg::TOL_RESET;
            mismatches = 0;
        endfunction

        function int axis_gap(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function bit is_near(box_edges_t a, box_edges_t b);
            int tol;
            tol = int'(tolerance);
            return axis_gap(a.left, b.left) < tol && axis_gap(a.top, b.top) < tol &&
                   axis_gap(a.right, b.right) < tol && axis_gap(a.bottom, b.bottom) < tol;
        endfunction

        // first match wins; unmatched boxes go to the end of the table if there is room
        function void note_box(box_beat_t b);
            box_edges_t    e;
            dedup_result_t r;
            bit            hit;
            e.left   = {1'b0, b.x};
            e.top    = {1'b0, b.y};
            e.right  = {1'b0, b.x} + {1'b0, b.w};
            e.bottom = {1'b0, b.y} + {1'b0, b.h};
            hit = 1'b0;
            foreach (seen_boxes[i])
            begin
                if (!hit && is_near(e, seen_boxes[i]))
                    hit = 1'b1;
            end
            if (hit)
                r.status = bdt_pkg::STATUS_MATCH;
            else if (seen_boxes.size() < capacity)
            begin
                seen_boxes = {seen_boxes, e};
                r.status = bdt_pkg::STATUS_NEW;
            end
            else
                r.status = bdt_pkg::STATUS_FULL;
            r.count = bdt_pkg::COUNT_OUT_W'(seen_boxes.size());
            due_results = {due_results, r};
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [1:0] status, logic [bdt_pkg::COUNT_OUT_W-1:0] count);
            dedup_result_t r;
            if (due_results.size() == 0)
            begin
                report($sformatf("result beat with nothing due (status %0d count %0d)",
                                 status, count));
                return;
            end
            r = due_results.pop_front();
            if (status !== r.status)
                report($sformatf("match_status %0d, predicted %0d", status, r.status));
            if (count !== r.count)
                report($sformatf("distinct_count %0d, predicted %0d", count, r.count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;

    bdt_box_if box_ch();
    bdt_res_if res_ch();
    bdt_cfg_if cfg_ch();

    dedup_scoreboard dedup = new(TABLE_DEPTH);

    box_dedup_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .box    (box_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int jitter(int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // mostly near copies of stored boxes, the rest uniform noise
    function automatic box_beat_t random_box();
        box_beat_t  b;
        box_edges_t ref_e;
        int         reach;
        int         left;
        int         top;
        int         right;
        int         bottom;
        if (dedup.seen_boxes.size() == 0 || $urandom_range(0, 99) < 30)
        begin
            b.x = bdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            b.y = bdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            b.w = bdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            b.h = bdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            return b;
        end
        ref_e = dedup.seen_boxes[$urandom_range(0, dedup.seen_boxes.size() - 1)];
        reach = (dedup.tolerance > 1000) ? COORD_MAX : int'(dedup.tolerance) + 2;
        if ($urandom_range(0, 9) == 0)
            reach = 0;
        left   = clamp(int'(ref_e.left) + jitter(reach), 0, COORD_MAX);
        top    = clamp(int'(ref_e.top) + jitter(reach), 0, COORD_MAX);
        right  = clamp(int'(ref_e.right) + jitter(reach), left, left + COORD_MAX);
        bottom = clamp(int'(ref_e.bottom) + jitter(reach), top, top + COORD_MAX);
        b.x = bdt_pkg::COORD_W'(left);
        b.y = bdt_pkg::COORD_W'(top);
        b.w = bdt_pkg::COORD_W'(right - left);
        b.h = bdt_pkg::COORD_W'(bottom - top);
        return b;
    endfunction

    // one box beat; valid stays high into the next beat when no gap is drawn
    task automatic send_box(input box_beat_t b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            if (box_ch.valid)
                box_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_ch.valid      <= 1'b1;
        box_ch.box_x      <= b.x;
        box_ch.box_y      <= b.y;
        box_ch.box_width  <= b.w;
        box_ch.box_height <= b.h;
        do @(posedge clk); while (!box_ch.ready);
        dedup.note_box(b);
    endtask

    task automatic send_coords(input int x, input int y, input int w, input int h);
        box_beat_t b;
        b.x = bdt_pkg::COORD_W'(x);
        b.y = bdt_pkg::COORD_W'(y);
        b.w = bdt_pkg::COORD_W'(w);
        b.h = bdt_pkg::COORD_W'(h);
        send_box(b);
    endtask

    // hold the sender until every due result has come back
    task automatic drain_results();
        if (box_ch.valid)
            box_ch.valid <= 1'b0;
        while (dedup.due_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [bdt_pkg::COORD_W-1:0] tol);
        drain_results();
        cfg_ch.valid            <= 1'b1;
        cfg_ch.corner_tolerance <= tol;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        dedup.tolerance = tol;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // stretches of back-to-back beats on both sides
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
                drain_results();
            send_box(random_box());
        end
    endtask

    // result sink with a random stall before each beat
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            dedup.check_result(res_ch.match_status, res_ch.distinct_count);
    end

    // stimulus
    initial
    begin
        logic [bdt_pkg::COORD_W-1:0] tol;
        rst_n                   <= 1'b0;
        box_ch.valid            <= 1'b0;
        box_ch.box_x            <= '0;
        box_ch.box_y            <= '0;
        box_ch.box_width        <= '0;
        box_ch.box_height       <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.corner_tolerance <= bdt_pkg::TOL_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tolerance: repeats, distances just under and at the bound, extremes
        send_coords(0, 0, 0, 0);
        send_coords(0, 0, 0, 0);
        send_coords(29, 29, 0, 0);
        send_coords(30, 0, 0, 0);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1);
        send_coords(COORD_MAX, COORD_MAX, 0, 0);
        send_coords(0, COORD_MAX, COORD_MAX, 0);
        send_coords(COORD_MAX, 0, 0, COORD_MAX);
        // far corner alone decides the match
        send_coords(500, 500, 100, 100);
        send_coords(500, 500, 130, 100);
        send_coords(500, 500, 129, 100);
        send_coords(500, 500, 100, 71);
        send_coords(682, 341, 341, 682);
        send_coords(341, 682, 682, 341);

        // zero tolerance: even an exact repeat is a new box
        write_tolerance('0);
        send_coords(0, 0, 0, 0);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

        // fill the table
        write_tolerance(bdt_pkg::TOL_RESET);
        run_random(400);

        // widest tolerance on a full table
        write_tolerance(bdt_pkg::COORD_W'(COORD_MAX));
        send_coords(0, 0, 0, 0);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_coords(0, 0, COORD_MAX, COORD_MAX);
        run_random(300);

        // tightest tolerance: only exact repeats match, the rest is dropped
        write_tolerance(bdt_pkg::COORD_W'(1));
        send_coords(0, 0, 0, 0);
        send_coords(1, 0, 0, 0);
        run_random(300);

        write_tolerance('0);
        run_random(150);

        repeat (4)
        begin
            if ($urandom_range(0, 1) == 0)
                tol = bdt_pkg::COORD_W'($urandom_range(1, 64));
            else
                tol = bdt_pkg::COORD_W'($urandom_range(1, COORD_MAX));
            write_tolerance(tol);
            run_random(150);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dedup.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
